// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define BSC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent now implies consequent in the next cycle.
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/bsc_pkg.sv -----
package bsc_pkg;

  localparam int MAX_PROCS_DEF   = 16;
  localparam int MAX_RES_DEF     = 8;
  localparam int AMOUNT_BITS_DEF = 16;

  // fixed field widths
  localparam int REQ_W      = 2;
  localparam int PIDX_W     = 4;
  localparam int RIDX_W     = 3;
  localparam int AMT_W      = 16;
  localparam int SLOT_W     = 4;
  localparam int WAMT_W     = 21;
  localparam int PCNT_W     = 5;
  localparam int RCNT_W     = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_MAX   = 2'd1,
    REQ_AVAIL = 2'd2,
    REQ_RUN   = 2'd3
  } req_t;

  typedef enum logic {
    KIND_ORDER = 1'b0,
    KIND_WORK  = 1'b1
  } kind_t;

  typedef enum logic {
    REG_PROC_COUNT = 1'b0,
    REG_RES_COUNT  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_PICK,
    ST_READ,
    ST_WAIT,
    ST_ORDER,
    ST_WORK
  } st_t;

endpackage

// ----- hw/rtl/bsc_in_if.sv -----
interface bsc_in_if import bsc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [PIDX_W-1:0] proc_index;
  logic [RIDX_W-1:0] res_index;
  logic [AMT_W-1:0]  amount;

  modport source (output valid, req_type, proc_index, res_index, amount, input ready);
  modport sink   (input valid, req_type, proc_index, res_index, amount, output ready);
endinterface

// ----- hw/rtl/bsc_out_if.sv -----
interface bsc_out_if import bsc_pkg::*;;
  logic              valid;
  logic              ready;
  logic              out_kind;
  logic [SLOT_W-1:0] slot;
  logic [WAMT_W-1:0] work_amount;
  logic              is_safe;
  logic              last;

  modport source (output valid, out_kind, slot, work_amount, is_safe, last, input ready);
  modport sink   (input valid, out_kind, slot, work_amount, is_safe, last, output ready);
endinterface

// ----- hw/rtl/bankers_safety_check.sv -----
// Banker's algorithm safety check.
// in_ch (valid/ready) carries load and run items. Loads write one entry of
// the allocation table, the maximum table or the available vector; they
// produce no result. A run item copies available into work and makes
// proc_count passes over the processes in ascending order. Per pass, a
// finished process is only picked and skipped; an unfinished one goes
// through pick, one table read per resource and a decision, since both
// tables sit in single-read-port RAMs walked one entry per cycle.
// The run then streams the finished ids followed by the final work vector
// on out_ch, one item per cycle while out_ch.ready is high; is_safe is set
// on every item when all processes finished, last marks the final one.
// A run gives at most P + R output items (P = proc_count, R = res_count).
// in_ch.ready is high only while idle; the next item is taken as soon as
// the final result sits in the output register, even if it is stalled.
// A stalled out_ch freezes the output walk. APB registers: proc_count at
// 0x0, res_count at 0x4; zero counts act as 1 and large ones saturate.
// Reset (rst_n, synchronous) clears control state and the counts to 1;
// the tables hold nothing valid until loaded.
`include "assert_macros.svh"

module bankers_safety_check import bsc_pkg::*; #(
  parameter int MAX_PROCS   = MAX_PROCS_DEF,
  parameter int MAX_RES     = MAX_RES_DEF,
  parameter int AMOUNT_BITS = AMOUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bsc_in_if.sink                in_ch,
  bsc_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int PI_W   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int PC_W   = $clog2(MAX_PROCS + 1);
  localparam int RI_W   = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int RC_W   = $clog2(MAX_RES + 1);
  localparam int DEPTH  = MAX_PROCS * MAX_RES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // avail plus every allocation stays below (MAX_PROCS+1) * 2^AMOUNT_BITS
  localparam int WORK_W = AMOUNT_BITS + $clog2(MAX_PROCS + 1);
  localparam int SUM_W  = WORK_W + 1;

  // ---------------- configuration registers ----------------
  logic [PCNT_W-1:0] proc_count_r;
  logic [RCNT_W-1:0] res_count_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_count_r <= PCNT_W'(1);
      res_count_r  <= RCNT_W'(1);
    end else if (cfg_wr) begin
      case (cfg_reg_t'(paddr[2]))
        REG_PROC_COUNT: proc_count_r <= pwdata[PCNT_W-1:0];
        REG_RES_COUNT:  res_count_r  <= pwdata[RCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_t'(paddr[2]))
      REG_PROC_COUNT: prdata = CFG_DATA_W'(proc_count_r);
      REG_RES_COUNT:  prdata = CFG_DATA_W'(res_count_r);
      default:        prdata = '0;
    endcase
  end

  // ---------------- state ----------------
  st_t               state_r, state_nxt;
  logic [PI_W-1:0]   i_r, i_nxt;          // process under test
  logic [PI_W-1:0]   pass_r, pass_nxt;
  logic [RI_W-1:0]   j_r, j_nxt;          // resource being issued
  logic [ADDR_W-1:0] row_r, row_nxt;      // i_r * MAX_RES
  logic              rd_v_r, rd_v_nxt;    // RAM data valid this cycle
  logic [RI_W-1:0]   rd_j_r, rd_j_nxt;
  logic              fits_r, fits_nxt;
  logic [PC_W-1:0]   cnt_r, cnt_nxt;      // finished processes
  logic [PC_W-1:0]   np_r, np_nxt;
  logic [RC_W-1:0]   nr_r, nr_nxt;
  logic [PI_W-1:0]   eo_r, eo_nxt;        // order emit index
  logic [RI_W-1:0]   ew_r, ew_nxt;        // work emit index
  logic [MAX_PROCS-1:0] done_r, done_nxt;

  logic [AMOUNT_BITS-1:0] avail_r [MAX_RES];
  logic [WORK_W-1:0]      work_r  [MAX_RES];
  logic [WORK_W-1:0]      tmp_r   [MAX_RES];
  logic [PI_W-1:0]        order_r [MAX_PROCS];

  // output register
  logic              out_v_r, out_v_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [WAMT_W-1:0] out_amt_r, out_amt_nxt;
  logic              out_safe_r, out_safe_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_ld, out_free;

  // ---------------- input side ----------------
  logic                   in_acc;
  logic [AMOUNT_BITS-1:0] amt_in;
  logic                   tbl_in_range;
  logic [ADDR_W-1:0]      load_addr;
  logic                   alloc_we, max_we;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign amt_in       = AMOUNT_BITS'(in_ch.amount);
  assign tbl_in_range = (int'(in_ch.proc_index) < MAX_PROCS) &&
                        (int'(in_ch.res_index) < MAX_RES);
  assign load_addr    = ADDR_W'(int'(in_ch.proc_index) * MAX_RES + int'(in_ch.res_index));
  assign alloc_we     = in_acc && tbl_in_range && (req_t'(in_ch.req_type) == REQ_ALLOC);
  assign max_we       = in_acc && tbl_in_range && (req_t'(in_ch.req_type) == REQ_MAX);

  always_ff @(posedge clk) begin
    if (in_acc && (req_t'(in_ch.req_type) == REQ_AVAIL) &&
        (int'(in_ch.res_index) < MAX_RES)) begin
      avail_r[RI_W'(in_ch.res_index)] <= amt_in;
    end
  end

  // ---------------- tables ----------------
  logic [ADDR_W-1:0]      rd_addr;
  logic [AMOUNT_BITS-1:0] alloc_q, max_q;

  assign rd_addr = row_r + ADDR_W'(j_r);

  bsc_table_ram #(.DEPTH(DEPTH), .WIDTH(AMOUNT_BITS)) u_alloc_ram (
    .clk   (clk),
    .we    (alloc_we),
    .waddr (load_addr),
    .wdata (amt_in),
    .raddr (rd_addr),
    .rdata (alloc_q)
  );

  bsc_table_ram #(.DEPTH(DEPTH), .WIDTH(AMOUNT_BITS)) u_max_ram (
    .clk   (clk),
    .we    (max_we),
    .waddr (load_addr),
    .wdata (amt_in),
    .raddr (rd_addr),
    .rdata (max_q)
  );

  // need <= work  <=>  max <= alloc + work; the sum is also the new work
  logic [SUM_W-1:0] sum;
  logic             res_ok, fits_now, commit;

  assign sum      = SUM_W'(alloc_q) + SUM_W'(work_r[rd_j_r]);
  assign res_ok   = SUM_W'(max_q) <= sum;
  assign fits_now = fits_r && res_ok;
  assign commit   = (state_r == ST_WAIT) && fits_now;
  assign out_free = !out_v_r || out_ch.ready;

  // ---------------- sequencer ----------------
  always_comb begin
    int  pc_val;
    int  rc_val;
    logic adv;
    pc_val = int'(proc_count_r);
    rc_val = int'(res_count_r);
    adv    = 1'b0;

    state_nxt    = state_r;
    i_nxt        = i_r;
    pass_nxt     = pass_r;
    j_nxt        = j_r;
    row_nxt      = row_r;
    rd_v_nxt     = 1'b0;
    rd_j_nxt     = rd_j_r;
    fits_nxt     = fits_r;
    cnt_nxt      = cnt_r;
    np_nxt       = np_r;
    nr_nxt       = nr_r;
    eo_nxt       = eo_r;
    ew_nxt       = ew_r;
    done_nxt     = done_r;
    out_ld       = 1'b0;
    out_kind_nxt = out_kind_r;
    out_slot_nxt = out_slot_r;
    out_amt_nxt  = out_amt_r;
    out_safe_nxt = out_safe_r;
    out_last_nxt = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (req_t'(in_ch.req_type) == REQ_RUN)) begin
          np_nxt    = PC_W'((pc_val == 0) ? 1 : ((pc_val > MAX_PROCS) ? MAX_PROCS : pc_val));
          nr_nxt    = RC_W'((rc_val == 0) ? 1 : ((rc_val > MAX_RES) ? MAX_RES : rc_val));
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        done_nxt  = '0;
        cnt_nxt   = '0;
        i_nxt     = '0;
        pass_nxt  = '0;
        row_nxt   = '0;
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (done_r[i_r]) begin
          adv = 1'b1;
        end else begin
          j_nxt     = '0;
          fits_nxt  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        rd_v_nxt = 1'b1;
        rd_j_nxt = j_r;
        if (rd_v_r) begin
          fits_nxt = fits_now;
        end
        if (RC_W'(j_r) == nr_r - RC_W'(1)) begin
          state_nxt = ST_WAIT;
        end else begin
          j_nxt = j_r + RI_W'(1);
        end
      end
      ST_WAIT: begin
        if (fits_now) begin
          done_nxt[i_r] = 1'b1;
          cnt_nxt       = cnt_r + PC_W'(1);
        end
        adv = 1'b1;
      end
      ST_ORDER: begin
        if (out_free) begin
          out_ld       = 1'b1;
          out_kind_nxt = KIND_ORDER;
          out_slot_nxt = SLOT_W'(order_r[eo_r]);
          out_amt_nxt  = '0;
          out_safe_nxt = (cnt_r == np_r);
          out_last_nxt = 1'b0;
          if (PC_W'(eo_r) == cnt_r - PC_W'(1)) begin
            ew_nxt    = '0;
            state_nxt = ST_WORK;
          end else begin
            eo_nxt = eo_r + PI_W'(1);
          end
        end
      end
      ST_WORK: begin
        if (out_free) begin
          out_ld       = 1'b1;
          out_kind_nxt = KIND_WORK;
          out_slot_nxt = SLOT_W'(ew_r);
          out_amt_nxt  = WAMT_W'(work_r[ew_r]);
          out_safe_nxt = (cnt_r == np_r);
          out_last_nxt = (RC_W'(ew_r) == nr_r - RC_W'(1));
          if (RC_W'(ew_r) == nr_r - RC_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            ew_nxt = ew_r + RI_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // step to the next process; after the final pass start the output walk
    if (adv) begin
      if (PC_W'(i_r) == np_r - PC_W'(1)) begin
        i_nxt   = '0;
        row_nxt = '0;
        if (PC_W'(pass_r) == np_r - PC_W'(1)) begin
          eo_nxt    = '0;
          ew_nxt    = '0;
          state_nxt = (cnt_nxt == '0) ? ST_WORK : ST_ORDER;
        end else begin
          pass_nxt  = pass_r + PI_W'(1);
          state_nxt = ST_PICK;
        end
      end else begin
        i_nxt     = i_r + PI_W'(1);
        row_nxt   = row_r + ADDR_W'(MAX_RES);
        state_nxt = ST_PICK;
      end
    end

    out_v_nxt = out_ld ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rd_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      done_r  <= '0;
      cnt_r   <= '0;
      np_r    <= PC_W'(1);
      nr_r    <= RC_W'(1);
      i_r     <= '0;
      pass_r  <= '0;
      j_r     <= '0;
      row_r   <= '0;
      eo_r    <= '0;
      ew_r    <= '0;
      fits_r  <= 1'b0;
      rd_j_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= rd_v_nxt;
      out_v_r <= out_v_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
      np_r    <= np_nxt;
      nr_r    <= nr_nxt;
      i_r     <= i_nxt;
      pass_r  <= pass_nxt;
      j_r     <= j_nxt;
      row_r   <= row_nxt;
      eo_r    <= eo_nxt;
      ew_r    <= ew_nxt;
      fits_r  <= fits_nxt;
      rd_j_r  <= rd_j_nxt;
    end
  end

  // payload: work vector, candidate sums, safe order, output register
  always_ff @(posedge clk) begin
    if (state_r == ST_INIT) begin
      for (int k = 0; k < MAX_RES; k++) begin
        work_r[k] <= WORK_W'(avail_r[k]);
      end
    end else if (commit) begin
      for (int k = 0; k < MAX_RES; k++) begin
        work_r[k] <= (RI_W'(k) == rd_j_r) ? WORK_W'(sum) : tmp_r[k];
      end
    end
    if (rd_v_r) begin
      tmp_r[rd_j_r] <= WORK_W'(sum);
    end
    if (commit) begin
      order_r[cnt_r[PI_W-1:0]] <= i_r;
    end
    if (out_ld) begin
      out_kind_r <= out_kind_nxt;
      out_slot_r <= out_slot_nxt;
      out_amt_r  <= out_amt_nxt;
      out_safe_r <= out_safe_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.out_kind    = out_kind_r;
  assign out_ch.slot        = out_slot_r;
  assign out_ch.work_amount = out_amt_r;
  assign out_ch.is_safe     = out_safe_r;
  assign out_ch.last        = out_last_r;

  // ---------------- assertions ----------------
  `BSC_ASSERT(a_done_matches_cnt, clk, rst_n, $countones(done_r) == int'(cnt_r), "done flags disagree with order count")
  `BSC_ASSERT(a_wait_has_data, clk, rst_n, (state_r == ST_WAIT) |-> rd_v_r, "decision without table data")
  `BSC_ASSERT(a_cnt_bound, clk, rst_n, (state_r != ST_IDLE && state_r != ST_INIT) |-> (cnt_r <= np_r), "order count exceeds process count")
  `BSC_ASSERT_NEXT(a_load_stays_idle, clk, rst_n, in_acc && (req_t'(in_ch.req_type) != REQ_RUN), state_r == ST_IDLE, "load item left idle")

endmodule

// ----- hw/rtl/bsc_table_ram.sv -----
// Simple dual-port RAM, registered read.
module bsc_table_ram import bsc_pkg::*; #(
  parameter int  DEPTH = MAX_PROCS_DEF * MAX_RES_DEF,
  parameter int  WIDTH = AMOUNT_BITS_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
